>>> rtl/rte_pkg.sv
package rte_pkg;

	// opcodes of a request transaction
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_DEL    = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// status codes of a response transaction
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	// request payload
	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] dest_addr;
		logic [31:0] net_mask;
		logic [31:0] gateway_addr;
		logic [31:0] source_addr;
		logic [3:0]  device_id;
		logic [31:0] route_metric;
	} rte_req_t;

	// response payload
	typedef struct packed {
		logic [1:0]  status;
		logic        hit;
		logic [31:0] out_gateway;
		logic [31:0] out_source;
		logic [3:0]  out_device;
		logic [31:0] out_metric;
	} rte_rsp_t;

	// one stored route
	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [31:0] source;
		logic [3:0]  device;
		logic [31:0] metric;
	} rte_route_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} rte_state_t;

endpackage

>>> rtl/rte_route_mem.sv
module rte_route_mem #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  rte_pkg::rte_route_t      wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output rte_pkg::rte_route_t      rd_data
);

	rte_pkg::rte_route_t mem [DEPTH];
	rte_pkg::rte_route_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/ipv4_route_table_engine.sv
// IPv4 route table with add, delete and longest-cost-free lookup (lowest metric wins, earliest
// entry on ties). Routes live packed in one route memory with a registered read; the
// number of stored routes N is held in a counter. Add goes from accept straight to finish.
// Lookup and delete walk the memory one entry per cycle: a lookup or a missed delete reads
// all N entries, and a delete that hits also runs over the whole table wherever the hit is,
// since after the hit the tail of the table is moved down one slot per cycle through the same
// read and write ports. One transaction is worked on at a time; the next request is taken
// once the current response has moved into the output register, so a stalled response does
// not block the next request.
module ipv4_route_table_engine #(
	parameter int ROUTE_ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rte_pkg::rte_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rte_pkg::rte_rsp_t rsp
);

	localparam int IdxW = $clog2(ROUTE_ENTRIES);
	localparam int CntW = $clog2(ROUTE_ENTRIES + 1);

	rte_pkg::rte_state_t state_q, state_d;

	logic [CntW-1:0]     count_q;
	logic [CntW-1:0]     iss_q;
	logic                pend_s1;
	logic [IdxW-1:0]     idx_s1;
	logic [1:0]          op_q;
	logic [31:0]         addr_q;
	logic [31:0]         mask_q;
	rte_pkg::rte_rsp_t   res_q;
	rte_pkg::rte_rsp_t   rsp_q;
	logic                rsp_valid_q;

	logic                accept;
	logic                iss_more;
	logic                scan_done;
	logic                rd_en;
	logic                wr_en;
	logic [IdxW-1:0]     wr_addr;
	rte_pkg::rte_route_t wr_data;
	rte_pkg::rte_route_t rd_data;
	rte_pkg::rte_route_t new_route;
	logic                lk_better;
	logic                del_hit;
	logic                del_first;
	logic                out_free;
	logic                shift_wr;
	rte_pkg::rte_rsp_t   res_init;

	// route memory
	rte_route_mem #(
		.DEPTH(ROUTE_ENTRIES)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(iss_q[IdxW-1:0]),
		.rd_data(rd_data)
	);

	// compare on the entry coming out of memory
	assign iss_more  = iss_q < count_q;
	assign scan_done = !iss_more && !pend_s1;
	assign lk_better = pend_s1 && ((addr_q & rd_data.mask) == rd_data.dest)
		&& (!res_q.hit || rd_data.metric < res_q.out_metric);
	assign del_hit   = pend_s1 && (rd_data.dest == addr_q) && (rd_data.mask == mask_q);
	assign del_first = state_q == rte_pkg::S_SCAN && op_q == rte_pkg::OP_DEL && del_hit;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign new_route = '{
		dest:    req.dest_addr,
		mask:    req.net_mask,
		gateway: req.gateway_addr,
		source:  req.source_addr,
		device:  req.device_id,
		metric:  req.route_metric
	};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rte_pkg::S_IDLE: begin
				if (req_valid) begin
					if (req.opcode == rte_pkg::OP_DEL || req.opcode == rte_pkg::OP_LOOKUP) begin
						state_d = rte_pkg::S_SCAN;
					end else begin
						state_d = rte_pkg::S_FINISH;
					end
				end
			end
			rte_pkg::S_SCAN: begin
				if (op_q == rte_pkg::OP_DEL && del_hit) begin
					state_d = rte_pkg::S_SHIFT;
				end else if (scan_done) begin
					state_d = rte_pkg::S_FINISH;
				end
			end
			rte_pkg::S_SHIFT: begin
				if (scan_done) begin
					state_d = rte_pkg::S_FINISH;
				end
			end
			rte_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = rte_pkg::S_IDLE;
				end
			end
			default: state_d = rte_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_stall = 1'b1;
		accept    = 1'b0;
		rd_en     = 1'b0;
		shift_wr  = 1'b0;
		case (state_q)
			rte_pkg::S_IDLE: begin
				req_stall = 1'b0;
				accept    = req_valid;
			end
			rte_pkg::S_SCAN: begin
				rd_en = iss_more;
			end
			rte_pkg::S_SHIFT: begin
				rd_en    = iss_more;
				shift_wr = pend_s1;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	// memory write: append on add, move down one slot while shifting
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IdxW-1:0];
		wr_data = new_route;
		if (shift_wr) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 - IdxW'(1);
			wr_data = rd_data;
		end else if (accept && req.opcode == rte_pkg::OP_ADD
			&& count_q != CntW'(ROUTE_ENTRIES)) begin
			wr_en = 1'b1;
		end
	end

	// starting result of an accepted transaction
	always_comb begin
		res_init = '0;
		case (req.opcode)
			rte_pkg::OP_ADD: begin
				if (count_q == CntW'(ROUTE_ENTRIES)) begin
					res_init.status = rte_pkg::ST_FULL;
				end
			end
			rte_pkg::OP_DEL, rte_pkg::OP_LOOKUP: begin
				res_init.status = rte_pkg::ST_MISSING;
			end
			default: begin
				res_init.status = rte_pkg::ST_OK;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rte_pkg::S_IDLE;
			count_q     <= '0;
			iss_q       <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// read issue and pending data tracking
			if (accept) begin
				iss_q <= '0;
			end else if (del_first) begin
				iss_q <= CntW'(idx_s1) + CntW'(1);
			end else if (rd_en) begin
				iss_q <= iss_q + CntW'(1);
			end
			if (del_first) begin
				pend_s1 <= 1'b0;
			end else begin
				pend_s1 <= rd_en;
			end

			// route count
			if (accept && req.opcode == rte_pkg::OP_ADD && count_q != CntW'(ROUTE_ENTRIES)) begin
				count_q <= count_q + CntW'(1);
			end else if (state_q == rte_pkg::S_SHIFT && scan_done) begin
				count_q <= count_q - CntW'(1);
			end

			// output register
			if (state_q == rte_pkg::S_FINISH && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// transaction datapath
	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[IdxW-1:0];
		if (accept) begin
			op_q   <= req.opcode;
			addr_q <= req.dest_addr;
			mask_q <= req.net_mask;
			res_q  <= res_init;
		end else if (state_q == rte_pkg::S_SCAN) begin
			if (op_q == rte_pkg::OP_LOOKUP && lk_better) begin
				res_q.status      <= rte_pkg::ST_OK;
				res_q.hit         <= 1'b1;
				res_q.out_gateway <= rd_data.gateway;
				res_q.out_source  <= rd_data.source;
				res_q.out_device  <= rd_data.device;
				res_q.out_metric  <= rd_data.metric;
			end
			if (op_q == rte_pkg::OP_DEL && del_hit) begin
				res_q.status <= rte_pkg::ST_OK;
			end
		end
		if (state_q == rte_pkg::S_FINISH && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// the route count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(ROUTE_ENTRIES))
		else $error("route count beyond table size");

	// the route count moves by at most one per transaction
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + CntW'(1) || count_q == $past(count_q) - CntW'(1)))
		else $error("route count jumped");

	// a shift write stays inside the stored routes
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		shift_wr |-> (CntW'(idx_s1) < count_q && idx_s1 != '0))
		else $error("shift write outside table");

	// a new response only comes from the finish state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == rte_pkg::S_FINISH)
		else $error("response raised outside finish");

	// a lookup hit always reports success
	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rte_pkg::S_FINISH && res_q.hit) |-> res_q.status == rte_pkg::ST_OK)
		else $error("hit without success status");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int unsigned ROUTES      = 16;
	localparam int unsigned ITEMS       = 2000;
	localparam int unsigned HOLD_AT     = 3000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_WAIT  = 60;

	// opcode the block does not define
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// mirror of the route table and the replies it predicts
	class route_mirror;
		rte_pkg::rte_route_t routes [ROUTES];
		int unsigned         route_count;
		rte_pkg::rte_rsp_t   awaited_replies [$];
		int unsigned         mismatches;

		function new();
			route_count = 0;
			mismatches  = 0;
		endfunction

		// update the table for an accepted request transaction and queue its reply
		function void apply_request(rte_pkg::rte_req_t r);
			rte_pkg::rte_rsp_t e;
			int                found;
			int                best;
			e = '0;
			case (r.opcode)
				rte_pkg::OP_ADD: begin
					if (route_count >= ROUTES) begin
						e.status = rte_pkg::ST_FULL;
					end else begin
						routes[route_count].dest    = r.dest_addr;
						routes[route_count].mask    = r.net_mask;
						routes[route_count].gateway = r.gateway_addr;
						routes[route_count].source  = r.source_addr;
						routes[route_count].device  = r.device_id;
						routes[route_count].metric  = r.route_metric;
						route_count++;
						e.status = rte_pkg::ST_OK;
					end
				end
				rte_pkg::OP_DEL: begin
					found = -1;
					for (int i = 0; i < route_count; i++)
						if (found < 0 && routes[i].dest == r.dest_addr && routes[i].mask == r.net_mask)
							found = i;
					if (found < 0) begin
						e.status = rte_pkg::ST_MISSING;
					end else begin
						// close the gap, the rest keep their order
						for (int i = found; i + 1 < route_count; i++)
							routes[i] = routes[i + 1];
						route_count--;
						e.status = rte_pkg::ST_OK;
					end
				end
				rte_pkg::OP_LOOKUP: begin
					best = -1;
					for (int i = 0; i < route_count; i++)
						if ((r.dest_addr & routes[i].mask) == routes[i].dest &&
						    (best < 0 || routes[i].metric < routes[best].metric))
							best = i;
					if (best < 0) begin
						e.status = rte_pkg::ST_MISSING;
					end else begin
						e.status      = rte_pkg::ST_OK;
						e.hit         = 1'b1;
						e.out_gateway = routes[best].gateway;
						e.out_source  = routes[best].source;
						e.out_device  = routes[best].device;
						e.out_metric  = routes[best].metric;
					end
				end
				default: ;
			endcase
			awaited_replies.push_back(e);
		endfunction

		function void flag(string field, logic [31:0] exp_val, logic [31:0] act_val);
			$error("%s mismatch: expected %h, got %h", field, exp_val, act_val);
			mismatches++;
		endfunction

		// compare a response transaction with the oldest awaited reply
		function void check_reply(rte_pkg::rte_rsp_t a);
			rte_pkg::rte_rsp_t e;
			if (awaited_replies.size() == 0) begin
				$error("response transaction with none awaited: status %h hit %h", a.status, a.hit);
				mismatches++;
				return;
			end
			e = awaited_replies.pop_front();
			if (a.status !== e.status)           flag("status", e.status, a.status);
			if (a.hit !== e.hit)                 flag("hit", e.hit, a.hit);
			if (a.out_gateway !== e.out_gateway) flag("out_gateway", e.out_gateway, a.out_gateway);
			if (a.out_source !== e.out_source)   flag("out_source", e.out_source, a.out_source);
			if (a.out_device !== e.out_device)   flag("out_device", e.out_device, a.out_device);
			if (a.out_metric !== e.out_metric)   flag("out_metric", e.out_metric, a.out_metric);
		endfunction
	endclass

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	rte_pkg::rte_req_t req       = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rte_pkg::rte_rsp_t rsp;

	route_mirror mirror = new();
	logic [31:0] net_pool [8];

	ipv4_route_table_engine #(
		.ROUTE_ENTRIES(ROUTES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(10_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	// check every accepted response transaction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			mirror.check_reply(rsp);
	end

	// response stall pattern, with one long hold-off to back up the request side
	initial begin
		int unsigned cycles;
		int unsigned hold_left;
		int unsigned run_left;
		int unsigned mode;
		cycles    = 0;
		hold_left = 0;
		run_left  = 0;
		mode      = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles == HOLD_AT)
				hold_left = HOLD_CYCLES;
			if (run_left == 0) begin
				mode     = $urandom_range(0, 3);
				run_left = $urandom_range(1, 60);
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				run_left--;
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					2: rsp_stall <= 1'($urandom_range(0, 1));
					default: rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	function automatic logic [31:0] prefix_mask(int unsigned len);
		return (len == 0) ? 32'h0 : (32'hffff_ffff << (32 - len));
	endfunction

	// offer one request transaction and wait until it is taken
	task automatic push_request(input rte_pkg::rte_req_t r);
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		mirror.apply_request(r);
	endtask

	task automatic send_route(input logic [1:0] op, input logic [31:0] dest,
	                          input logic [31:0] mask, input logic [31:0] gw,
	                          input logic [31:0] src, input logic [3:0] dev,
	                          input logic [31:0] metric);
		rte_pkg::rte_req_t r;
		r.opcode       = op;
		r.dest_addr    = dest;
		r.net_mask     = mask;
		r.gateway_addr = gw;
		r.source_addr  = src;
		r.device_id    = dev;
		r.route_metric = metric;
		push_request(r);
	endtask

	// mostly well-formed routes from a few shared networks so prefixes overlap
	function automatic rte_pkg::rte_req_t random_request(int unsigned add_pct,
	                                                     int unsigned del_pct);
		rte_pkg::rte_req_t   r;
		rte_pkg::rte_route_t known;
		int unsigned         roll;
		int unsigned         len;
		logic [31:0]         base;
		r.opcode       = rte_pkg::OP_LOOKUP;
		r.dest_addr    = $urandom;
		r.net_mask     = $urandom;
		r.gateway_addr = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom;
		r.source_addr  = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom;
		r.device_id    = 4'($urandom);
		r.route_metric = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom;
		base = net_pool[$urandom_range(0, 7)];
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			r.opcode = OP_UNUSED;
		end else if (roll < 2 + add_pct) begin
			r.opcode = rte_pkg::OP_ADD;
			len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(8, 32);
			r.net_mask = prefix_mask(len);
			if ($urandom_range(0, 9) != 0)
				r.dest_addr = (base | ($urandom & 32'h0000_0f0f)) & r.net_mask;
		end else if (roll < 2 + add_pct + del_pct) begin
			r.opcode = rte_pkg::OP_DEL;
			if (mirror.route_count != 0 && $urandom_range(0, 4) != 0) begin
				known       = mirror.routes[$urandom_range(0, mirror.route_count - 1)];
				r.dest_addr = known.dest;
				r.net_mask  = known.mask;
			end else begin
				r.net_mask  = prefix_mask($urandom_range(0, 32));
				r.dest_addr = base & r.net_mask;
			end
		end else begin
			if (mirror.route_count != 0 && $urandom_range(0, 9) < 6) begin
				known       = mirror.routes[$urandom_range(0, mirror.route_count - 1)];
				r.dest_addr = known.dest | ($urandom & ~known.mask);
			end else if ($urandom_range(0, 2) != 0) begin
				r.dest_addr = base | ($urandom & 32'h00ff_ffff);
			end
		end
		return r;
	endfunction

	// stimulus
	initial begin
		int unsigned       sent;
		int unsigned       burst;
		int unsigned       add_pct;
		int unsigned       del_pct;
		rte_pkg::rte_req_t r;

		foreach (net_pool[k])
			net_pool[k] = (k == 0) ? 32'h0 : $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unused opcode
		send_route(rte_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
		send_route(rte_pkg::OP_DEL, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
		send_route(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
		           4'hf, 32'hffff_ffff);
		// default route, host route, tie on equal metric
		send_route(rte_pkg::OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'hffff_ffff);
		send_route(rte_pkg::OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
		           4'hf, 32'h0);
		send_route(rte_pkg::OP_ADD, 32'h0a00_0000, 32'hff00_0000, 32'h0a00_0001, 32'h0a00_00fe,
		           4'h1, 32'd5);
		send_route(rte_pkg::OP_ADD, 32'h0a00_0000, 32'hff00_0000, 32'h0a00_0002, 32'h0,
		           4'h2, 32'd5);
		send_route(rte_pkg::OP_ADD, 32'h0a01_0000, 32'hffff_0000, 32'h0a01_0001, 32'h0,
		           4'h3, 32'd7);
		send_route(rte_pkg::OP_LOOKUP, 32'h0a01_0203, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
		send_route(rte_pkg::OP_LOOKUP, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
		send_route(rte_pkg::OP_LOOKUP, 32'hc0a8_0001, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
		// delete: mask mismatch, middle entry, head entry
		send_route(rte_pkg::OP_DEL, 32'h0a00_0000, 32'hffff_0000, 32'h0, 32'h0, 4'h0, 32'h0);
		send_route(rte_pkg::OP_DEL, 32'h0a00_0000, 32'hff00_0000, 32'h0, 32'h0, 4'h0, 32'h0);
		send_route(rte_pkg::OP_LOOKUP, 32'h0a01_0203, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
		send_route(rte_pkg::OP_DEL, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
		send_route(rte_pkg::OP_LOOKUP, 32'h0102_0304, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
		// fill the table, then one add too many
		while (mirror.route_count < ROUTES)
			push_request(random_request(98, 0));
		send_route(rte_pkg::OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);

		// random bursts, alternating fill-heavy and drain-heavy stretches
		sent = 0;
		while (sent < ITEMS) begin
			add_pct = ((sent / 200) % 2 == 0) ? 50 : 18;
			del_pct = ((sent / 200) % 2 == 0) ? 15 : 45;
			burst = $urandom_range(1, 40);
			repeat (burst) begin
				r = random_request(add_pct, del_pct);
				push_request(r);
				if (r.opcode != OP_UNUSED)
					sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
		req_valid <= 1'b0;

		// drain and finish
		while (mirror.awaited_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mirror.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
